@@ hdl/optical_power_to_dbm_core_defines.svh @@
// Assertion helpers shared by the converter modules.
// Each use expects clk and rst_n in scope.
`ifndef OPTICAL_POWER_TO_DBM_CORE_DEFINES_SVH
`define OPTICAL_POWER_TO_DBM_CORE_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define OPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Trigger in one cycle implies a consequence in the next.
`define OPD_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/opd_pkg.sv @@
package opd_pkg;

    // Field widths
    localparam int POWER_W = 16;
    localparam int LEAD_W  = 4;
    localparam int IDX_W   = 8;
    localparam int FRAC_W  = 7;
    localparam int MANT_W  = 16;
    localparam int LOG2_W  = 28;
    localparam int Q10_W   = 13;
    localparam int DBM_W   = 13;

    // log10(2) in Q31
    localparam logic [29:0] LOG10_2_Q31 = 30'd646456993;
    // Q24 log10 product is dropped to Q10: 31 + 14 bits off the bottom
    localparam int Q10_LSB = 45;
    localparam logic [9:0] DBM_SCALE = 10'd1000;
    // (4 << 10) * 1000 / 1024: 0.1 uW referred to 1 mW, in 0.01 dB
    localparam logic [DBM_W-1:0] DBM_OFFSET = 13'd4000;

    // Normalized word: leading-one position, table index, bits below index
    typedef struct packed {
        logic [LEAD_W-1:0] pos;
        logic [IDX_W-1:0]  idx;
        logic [FRAC_W-1:0] frac_bits;
    } norm_t;

    // Table result ready for interpolation
    typedef struct packed {
        logic [LEAD_W-1:0] pos;
        logic [MANT_W-1:0] mant;
        logic [MANT_W-1:0] step;
        logic [FRAC_W-1:0] frac_bits;
    } interp_t;

    // log2 mantissa table, Q16
    localparam logic [MANT_W-1:0] LOG2_MANT [256] = '{
        16'h0000, 16'h0171, 16'h02e0, 16'h044e, 16'h05ba, 16'h0725, 16'h088e, 16'h09f7,
        16'h0b5d, 16'h0cc3, 16'h0e27, 16'h0f8a, 16'h10eb, 16'h124b, 16'h13aa, 16'h1508,
        16'h1664, 16'h17bf, 16'h1919, 16'h1a71, 16'h1bc8, 16'h1d1e, 16'h1e73, 16'h1fc6,
        16'h2119, 16'h226a, 16'h23ba, 16'h2508, 16'h2656, 16'h27a2, 16'h28ed, 16'h2a37,
        16'h2b80, 16'h2cc8, 16'h2e0f, 16'h2f54, 16'h3098, 16'h31dc, 16'h331e, 16'h345f,
        16'h359f, 16'h36de, 16'h381b, 16'h3958, 16'h3a94, 16'h3bce, 16'h3d08, 16'h3e41,
        16'h3f78, 16'h40af, 16'h41e4, 16'h4319, 16'h444c, 16'h457f, 16'h46b0, 16'h47e1,
        16'h4910, 16'h4a3f, 16'h4b6c, 16'h4c99, 16'h4dc5, 16'h4eef, 16'h5019, 16'h5142,
        16'h526a, 16'h5391, 16'h54b7, 16'h55dc, 16'h5700, 16'h5824, 16'h5946, 16'h5a68,
        16'h5b89, 16'h5ca8, 16'h5dc7, 16'h5ee5, 16'h6003, 16'h611f, 16'h623a, 16'h6355,
        16'h646f, 16'h6588, 16'h66a0, 16'h67b7, 16'h68ce, 16'h69e4, 16'h6af8, 16'h6c0c,
        16'h6d20, 16'h6e32, 16'h6f44, 16'h7055, 16'h7165, 16'h7274, 16'h7383, 16'h7490,
        16'h759d, 16'h76aa, 16'h77b5, 16'h78c0, 16'h79ca, 16'h7ad3, 16'h7bdb, 16'h7ce3,
        16'h7dea, 16'h7ef0, 16'h7ff6, 16'h80fb, 16'h81ff, 16'h8302, 16'h8405, 16'h8507,
        16'h8608, 16'h8709, 16'h8809, 16'h8908, 16'h8a06, 16'h8b04, 16'h8c01, 16'h8cfe,
        16'h8dfa, 16'h8ef5, 16'h8fef, 16'h90e9, 16'h91e2, 16'h92db, 16'h93d2, 16'h94ca,
        16'h95c0, 16'h96b6, 16'h97ab, 16'h98a0, 16'h9994, 16'h9a87, 16'h9b7a, 16'h9c6c,
        16'h9d5e, 16'h9e4f, 16'h9f3f, 16'ha02e, 16'ha11e, 16'ha20c, 16'ha2fa, 16'ha3e7,
        16'ha4d4, 16'ha5c0, 16'ha6ab, 16'ha796, 16'ha881, 16'ha96a, 16'haa53, 16'hab3c,
        16'hac24, 16'had0c, 16'hadf2, 16'haed9, 16'hafbe, 16'hb0a4, 16'hb188, 16'hb26c,
        16'hb350, 16'hb433, 16'hb515, 16'hb5f7, 16'hb6d9, 16'hb7ba, 16'hb89a, 16'hb97a,
        16'hba59, 16'hbb38, 16'hbc16, 16'hbcf4, 16'hbdd1, 16'hbead, 16'hbf8a, 16'hc065,
        16'hc140, 16'hc21b, 16'hc2f5, 16'hc3cf, 16'hc4a8, 16'hc580, 16'hc658, 16'hc730,
        16'hc807, 16'hc8de, 16'hc9b4, 16'hca8a, 16'hcb5f, 16'hcc34, 16'hcd08, 16'hcddc,
        16'hceaf, 16'hcf82, 16'hd054, 16'hd126, 16'hd1f7, 16'hd2c8, 16'hd399, 16'hd469,
        16'hd538, 16'hd607, 16'hd6d6, 16'hd7a4, 16'hd872, 16'hd93f, 16'hda0c, 16'hdad9,
        16'hdba5, 16'hdc70, 16'hdd3b, 16'hde06, 16'hded0, 16'hdf9a, 16'he063, 16'he12c,
        16'he1f5, 16'he2bd, 16'he385, 16'he44c, 16'he513, 16'he5d9, 16'he69f, 16'he765,
        16'he82a, 16'he8ef, 16'he9b3, 16'hea77, 16'heb3b, 16'hebfe, 16'hecc1, 16'hed83,
        16'hee45, 16'hef06, 16'hefc8, 16'hf088, 16'hf149, 16'hf209, 16'hf2c8, 16'hf387,
        16'hf446, 16'hf505, 16'hf5c3, 16'hf680, 16'hf73e, 16'hf7fb, 16'hf8b7, 16'hf973,
        16'hfa2f, 16'hfaea, 16'hfba5, 16'hfc60, 16'hfd1a, 16'hfdd4, 16'hfe8e, 16'hff47
    };

endpackage

@@ hdl/opd_if.sv @@
// Power word channel
interface opd_power_if;
    logic                        valid;
    logic                        ready;
    logic [opd_pkg::POWER_W-1:0] power_word;

    modport source (output valid, output power_word, input ready);
    modport sink   (input valid, input power_word, output ready);
endinterface

// dBm word channel
interface opd_dbm_if;
    logic                             valid;
    logic                             ready;
    logic signed [opd_pkg::DBM_W-1:0] dbm_hundredths;

    modport source (output valid, output dbm_hundredths, input ready);
    modport sink   (input valid, input dbm_hundredths, output ready);
endinterface

@@ hdl/opd_norm.sv @@
`include "optical_power_to_dbm_core_defines.svh"

// Stage 1: leading-one search and normalization
module opd_norm
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  logic [opd_pkg::POWER_W-1:0] power_word,
    output logic                        dn_valid,
    input  logic                        dn_ready,
    output opd_pkg::norm_t              norm
);

    logic                        valid_reg;
    opd_pkg::norm_t              norm_reg;
    opd_pkg::norm_t              norm_next;
    logic [opd_pkg::LEAD_W-1:0]  lead;
    logic [opd_pkg::POWER_W-1:0] shifted;

    // Priority encode the highest set bit; zero maps to position 0
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < opd_pkg::POWER_W; i++)
        begin
            if (power_word[i])
            begin
                lead = opd_pkg::LEAD_W'(i);
            end
        end
    end

    // Leading one goes to the top bit; index and low bits follow it
    always_comb
    begin
        shifted             = power_word << (opd_pkg::LEAD_W'(opd_pkg::POWER_W - 1) - lead);
        norm_next.pos       = lead;
        norm_next.idx       = shifted[14:7];
        norm_next.frac_bits = shifted[6:0];
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign norm     = norm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            norm_reg <= norm_next;
        end
    end

    // A zero word normalizes to all zeros, the same as a word of one
    `OPD_ASSERT_NEXT(a_zero_word, up_valid && up_ready && (power_word == '0), norm_reg == '0, "zero word not cleared")
    // A stalled word holds its stage
    `OPD_ASSERT_NEXT(a_norm_hold, valid_reg && !dn_ready, valid_reg && $stable(norm_reg), "stage 1 lost a word")

endmodule

@@ hdl/opd_interp.sv @@
`include "optical_power_to_dbm_core_defines.svh"

// Stages 2 and 3: table lookup, then linear interpolation into log2 Q24
module opd_interp
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  opd_pkg::norm_t             norm,
    output logic                       dn_valid,
    input  logic                       dn_ready,
    output logic [opd_pkg::LOG2_W-1:0] log2_q24
);

    logic                              lut_valid_reg;
    opd_pkg::interp_t                  lut_reg;
    opd_pkg::interp_t                  lut_next;
    logic                              log_valid_reg;
    logic [opd_pkg::LOG2_W-1:0]        log_reg;
    logic [opd_pkg::LOG2_W-1:0]        log_next;
    logic                              lut_ready;
    logic                              log_ready;
    logic [opd_pkg::IDX_W-1:0]         idx_up;
    logic [opd_pkg::MANT_W-1:0]        mant_up;
    logic [opd_pkg::MANT_W+opd_pkg::FRAC_W-1:0] frac_prod;

    assign log_ready = !log_valid_reg || dn_ready;
    assign lut_ready = !lut_valid_reg || log_ready;
    assign up_ready  = lut_ready;
    assign dn_valid  = log_valid_reg;
    assign log2_q24  = log_reg;

    // Entry and slope to the next entry; last entry wraps to entry 0 mod 2^16
    always_comb
    begin
        idx_up             = norm.idx + 8'd1;
        mant_up            = opd_pkg::LOG2_MANT[idx_up];
        lut_next.pos       = norm.pos;
        lut_next.mant      = opd_pkg::LOG2_MANT[norm.idx];
        lut_next.step      = mant_up - opd_pkg::LOG2_MANT[norm.idx];
        lut_next.frac_bits = norm.frac_bits;
    end

    // Interpolation: low bits times slope, scaled by two into Q24
    always_comb
    begin
        frac_prod = {{opd_pkg::MANT_W{1'b0}}, lut_reg.frac_bits}
                  * {{opd_pkg::FRAC_W{1'b0}}, lut_reg.step};
        log_next  = {lut_reg.pos, 24'h0}
                  + {4'h0, lut_reg.mant, 8'h0}
                  + {4'h0, frac_prod, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lut_valid_reg <= 1'b0;
            log_valid_reg <= 1'b0;
        end
        else
        begin
            if (lut_ready)
            begin
                lut_valid_reg <= up_valid;
            end
            if (log_ready)
            begin
                log_valid_reg <= lut_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (lut_ready && up_valid)
        begin
            lut_reg <= lut_next;
        end
        if (log_ready && lut_valid_reg)
        begin
            log_reg <= log_next;
        end
    end

    // Fraction never carries into the integer part of log2
    `OPD_ASSERT_NEXT(a_log_int, lut_valid_reg && log_ready, log_reg[27:24] == $past(lut_reg.pos), "log2 fraction overflow")

endmodule

@@ hdl/opd_scale.sv @@
`include "optical_power_to_dbm_core_defines.svh"

// Stages 4 and 5: log2 to log10 in Q10, then to 0.01 dBm
module opd_scale
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  logic [opd_pkg::LOG2_W-1:0]        log2_q24,
    output logic                              dn_valid,
    input  logic                              dn_ready,
    output logic signed [opd_pkg::DBM_W-1:0]  dbm
);

    logic                       q10_valid_reg;
    logic [opd_pkg::Q10_W-1:0]  q10_reg;
    logic [opd_pkg::Q10_W-1:0]  q10_next;
    logic                       dbm_valid_reg;
    logic [opd_pkg::DBM_W-1:0]  dbm_reg;
    logic [opd_pkg::DBM_W-1:0]  dbm_next;
    logic                       q10_ready;
    logic                       dbm_ready;
    logic [57:0]                l10_prod;
    logic [22:0]                cb_prod;

    assign dbm_ready = !dbm_valid_reg || dn_ready;
    assign q10_ready = !q10_valid_reg || dbm_ready;
    assign up_ready  = q10_ready;
    assign dn_valid  = dbm_valid_reg;
    assign dbm       = $signed(dbm_reg);

    // log10 = log2 * log10(2); keep Q10 integer bits
    always_comb
    begin
        l10_prod = {30'h0, log2_q24} * {28'h0, opd_pkg::LOG10_2_Q31};
        q10_next = l10_prod[opd_pkg::Q10_LSB +: opd_pkg::Q10_W];
    end

    // Floor of q10 * 1000 / 1024, less the 0.1 uW reference; wraps to two's complement
    always_comb
    begin
        cb_prod  = {10'h0, q10_reg} * {13'h0, opd_pkg::DBM_SCALE};
        dbm_next = cb_prod[22:10] - opd_pkg::DBM_OFFSET;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q10_valid_reg <= 1'b0;
            dbm_valid_reg <= 1'b0;
        end
        else
        begin
            if (q10_ready)
            begin
                q10_valid_reg <= up_valid;
            end
            if (dbm_ready)
            begin
                dbm_valid_reg <= q10_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q10_ready && up_valid)
        begin
            q10_reg <= q10_next;
        end
        if (dbm_ready && q10_valid_reg)
        begin
            dbm_reg <= dbm_next;
        end
    end

    // Result stays within the converter's range
    `OPD_ASSERT(a_dbm_range, dbm_valid_reg |-> (($signed(dbm_reg) >= -13'sd4000) && ($signed(dbm_reg) <= 13'sd820)), "dBm out of range")

endmodule

@@ hdl/optical_power_to_dbm_core.sv @@
// Optical power to dBm converter. Takes one 16-bit power word (0.1 uW units)
// per cycle and returns the power in 0.01 dBm, two's complement, rounded
// toward minus infinity; words 0 and 1 both give -4000. The datapath is five
// register stages (leading-one normalize, log2 table lookup, interpolation,
// log10(2) scaling, dBm scaling), and a new word can enter every cycle unless
// the output stalls. Each stage has its own valid bit and stalls only when it
// is full and the stage after it cannot take its word, so the pipeline holds
// up to five words while the output waits.
// No configuration, no state between words.
module optical_power_to_dbm_core
(
    input  logic              clk,
    input  logic              rst_n,
    opd_power_if.sink         power_in,
    opd_dbm_if.source         dbm_out
);

    logic                       norm_valid;
    logic                       norm_ready;
    opd_pkg::norm_t             norm;
    logic                       log_valid;
    logic                       log_ready;
    logic [opd_pkg::LOG2_W-1:0] log2_q24;

    opd_norm u_norm
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (power_in.valid),
        .up_ready   (power_in.ready),
        .power_word (power_in.power_word),
        .dn_valid   (norm_valid),
        .dn_ready   (norm_ready),
        .norm       (norm)
    );

    opd_interp u_interp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (norm_valid),
        .up_ready (norm_ready),
        .norm     (norm),
        .dn_valid (log_valid),
        .dn_ready (log_ready),
        .log2_q24 (log2_q24)
    );

    opd_scale u_scale
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (log_valid),
        .up_ready (log_ready),
        .log2_q24 (log2_q24),
        .dn_valid (dbm_out.valid),
        .dn_ready (dbm_out.ready),
        .dbm      (dbm_out.dbm_hundredths)
    );

endmodule
